### src/mcbs_pkg.sv
// mcbs_pkg: shared types and constants for the mip chain byte size block.
// No dependencies; imported by every module under src.
package mcbs_pkg;

   localparam int DIM_W   = 15;  // texel dimension width
   localparam int BLK_W   = 5;   // block dimension width
   localparam int FAC_W   = 6;   // byte factor width (per texel or per block)
   localparam int NUM_W   = 16;  // divider numerator / quotient width
   localparam int PROD_W  = 51;  // full level byte count
   localparam int PART_W  = 36;  // partial product before the last multiply
   localparam int TOTAL_W = 48;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   localparam logic [1:0] KIND_1D = 2'd0;
   localparam logic [1:0] KIND_2D = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEVEL,
      ST_DIM,
      ST_DIV,
      ST_ACC,
      ST_DONE
   } state_type;

   // multiply / accumulate unit controls
   typedef struct packed {
      logic prod_load;    // product <= operand
      logic prod_mul;     // product <= product * operand
      logic total_clear;  // total <= 0
      logic total_add;    // total <= sat(total + product)
   } mac_ctl_type;

endpackage

### src/mcbs_div.sv
// mcbs_div: restoring divider, one quotient bit per cycle, 16 steps.
// Depends on mcbs_pkg for widths.
module mcbs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mcbs_pkg::NUM_W-1:0]    numerator,
   input  logic [mcbs_pkg::BLK_W-1:0]    divisor,
   output logic                          done,
   output logic [mcbs_pkg::NUM_W-1:0]    quotient
);
   import mcbs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0]    num_ff, num_in;    // numerator shifts out, quotient shifts in
   logic [BLK_W-1:0]    rem_ff, rem_in;
   logic [BLK_W-1:0]    div_ff, div_in;
   logic [BLK_W:0]      trial;
   logic                fits;

   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = numerator;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], fits};
         rem_in = fits ? BLK_W'(trial - {1'b0, div_ff}) : trial[BLK_W-1:0];
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

### src/mcbs_mac.sv
// mcbs_mac: shared 36x15 multiplier with a product register and a
// saturating 48-bit total. Depends on mcbs_pkg.
module mcbs_mac (
   input  logic                           clock,
   input  mcbs_pkg::mac_ctl_type          ctl,
   input  logic [mcbs_pkg::DIM_W-1:0]     operand,
   output logic [mcbs_pkg::TOTAL_W-1:0]   total
);
   import mcbs_pkg::*;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [PROD_W:0]    sum;

   // partial product never exceeds 36 bits before the last multiply
   assign sum = {1'b0, prod_ff} + (PROD_W+1)'(total_ff);

   always_comb begin
      prod_in  = prod_ff;
      total_in = total_ff;
      if (ctl.prod_load) begin
         prod_in = PROD_W'(operand);
      end else if (ctl.prod_mul) begin
         prod_in = PROD_W'(prod_ff[PART_W-1:0] * operand);
      end
      if (ctl.total_clear) begin
         total_in = '0;
      end else if (ctl.total_add) begin
         total_in = (sum > (PROD_W+1)'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      total_ff <= total_in;
   end

   assign total = total_ff;

endmodule

### src/mip_chain_byte_size.sv
// mip_chain_byte_size: total byte size of a texture mip chain.
// Per item: clear the total, then per level load the byte factor, multiply in the three
// dimensions and add into the total; in a compressed item each block dimension above 1 runs the divider.
// One item at a time; req_stall drops in the same cycle that the result is registered;
// a previous result still stalled delays that.
// Reset (synchronous, active high) returns the sequencer to idle and clears rsp_valid.
module mip_chain_byte_size #(
   parameter int MAX_LEVELS = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [14:0]                    req_base_width,
   input  logic [14:0]                    req_base_height,
   input  logic [14:0]                    req_base_depth,
   input  logic [3:0]                     req_level_count,
   input  logic [1:0]                     req_image_kind,
   input  logic                           req_is_block_compressed,
   input  logic [4:0]                     req_block_width,
   input  logic [4:0]                     req_block_height,
   input  logic [4:0]                     req_block_depth,
   input  logic [4:0]                     req_bytes_per_block,
   input  logic [5:0]                     req_bytes_per_texel,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [mcbs_pkg::TOTAL_W-1:0]   rsp_total_bytes
);
   import mcbs_pkg::*;

   // --- item registers, captured at accept ---
   // Dimensions forced by the image kind are stored as 1, which stays 1 at every
   // level. Zero block dimensions are stored as 1.
   logic [DIM_W-1:0]   base_ff [3];
   logic [BLK_W-1:0]   blk_ff  [3];
   logic [FAC_W-1:0]   factor_ff;
   logic               comp_ff;
   logic [3:0]         lvl_cnt_ff, lvl_cnt_in;

   // --- sequencer state ---
   state_type          state_ff, state_in;
   logic [3:0]         lvl_ff, lvl_in;
   logic [1:0]         idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   logic               accept;
   logic [DIM_W-1:0]   shifted;
   logic [DIM_W-1:0]   dim;
   logic [BLK_W-1:0]   blk;
   logic [NUM_W-1:0]   div_num;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   quotient;
   mac_ctl_type        mac_ctl;
   logic [DIM_W-1:0]   mac_operand;
   logic [TOTAL_W-1:0] total;
   logic [4:0]         lc_ext;

   assign accept = req_valid && !req_stall;
   assign lc_ext = {1'b0, req_level_count};

   // current dimension at the current level, floor of 1
   assign blk     = blk_ff[idx_ff];
   assign shifted = base_ff[idx_ff] >> lvl_ff;
   assign dim     = (shifted == '0) ? DIM_W'(1) : shifted;
   // ceil(dim / blk) = floor((dim + blk - 1) / blk)
   assign div_num = {1'b0, dim} + NUM_W'(blk) - NUM_W'(1);

   // capture the item
   always_ff @(posedge clock) begin
      if (accept) begin
         base_ff[0] <= req_base_width;
         base_ff[1] <= (req_image_kind == KIND_1D) ? DIM_W'(1) : req_base_height;
         base_ff[2] <= (req_image_kind == KIND_1D || req_image_kind == KIND_2D) ?
                       DIM_W'(1) : req_base_depth;
         blk_ff[0]  <= (req_block_width  == '0) ? BLK_W'(1) : req_block_width;
         blk_ff[1]  <= (req_block_height == '0) ? BLK_W'(1) : req_block_height;
         blk_ff[2]  <= (req_block_depth  == '0) ? BLK_W'(1) : req_block_depth;
         factor_ff  <= req_is_block_compressed ? FAC_W'(req_bytes_per_block) :
                       req_bytes_per_texel;
         comp_ff    <= req_is_block_compressed;
      end
   end

   // sequencer: per level, load the byte factor, multiply in the three
   // dimensions (block counts when compressed), then add into the total
   always_comb begin
      state_in     = state_ff;
      lvl_in       = lvl_ff;
      lvl_cnt_in   = lvl_cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      mac_ctl      = '0;
      mac_operand  = dim;
      div_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mac_ctl.total_clear = 1'b1;
               lvl_in              = '0;
               // level count saturates at MAX_LEVELS
               lvl_cnt_in = (lc_ext > 5'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : req_level_count;
               state_in            = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            if (lvl_ff == lvl_cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               mac_ctl.prod_load = 1'b1;
               mac_operand       = DIM_W'(factor_ff);
               idx_in            = '0;
               state_in          = ST_DIM;
            end
         end
         ST_DIM: begin
            if (comp_ff && blk != BLK_W'(1)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               mac_ctl.prod_mul = 1'b1;
               idx_in           = idx_ff + 2'd1;
               state_in         = (idx_ff == 2'd2) ? ST_ACC : ST_DIM;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               // block count never exceeds the 15-bit dimension
               mac_operand      = quotient[DIM_W-1:0];
               mac_ctl.prod_mul = 1'b1;
               idx_in           = idx_ff + 2'd1;
               state_in         = (idx_ff == 2'd2) ? ST_ACC : ST_DIM;
            end
         end
         ST_ACC: begin
            mac_ctl.total_add = 1'b1;
            lvl_in            = lvl_ff + 4'd1;
            state_in          = ST_LEVEL;
         end
         ST_DONE: begin
            // output register frees up: hand over and return to idle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_total_in = total;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lvl_ff       <= lvl_in;
      lvl_cnt_ff   <= lvl_cnt_in;
      idx_ff       <= idx_in;
      rsp_total_ff <= rsp_total_in;
   end

   mcbs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (blk),
      .done      (div_done),
      .quotient  (quotient)
   );

   mcbs_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .operand (mac_operand),
      .total   (total)
   );

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_bytes = rsp_total_ff;

endmodule
